### hdl/msdp_pkg.sv
// Package for the masked share dot product block: widths, register codes and item types.
// Used by every module under hdl; depends on nothing else.
package msdp_pkg;

    // Width of the share arithmetic; all sums wrap modulo 2^WORD.
    localparam int WORD = 32;
    // Width of every payload field and of the configuration register.
    localparam int FIELD_W = 32;
    // APB address width: the register index sits at paddr[2].
    localparam int PADDR_W = 3;

    typedef logic [WORD-1:0]    word_t;
    typedef logic [FIELD_W-1:0] field_t;

    // Register indexes, taken from paddr[PADDR_W-1:2].
    typedef enum logic [PADDR_W-3:0] {
        REG_REFRESH_RANDOM = 1'b0
    } reg_idx_t;

    // One input item.
    typedef struct packed {
        field_t act_share0;
        field_t act_share1;
        field_t wgt_share0;
        field_t wgt_share1;
        field_t bias_share0;
        field_t bias_share1;
        logic   row_last;
    } in_item_t;

    // One result item.
    typedef struct packed {
        field_t sum_share0;
        field_t sum_share1;
    } out_item_t;

    // Product stage contents handed from the multiplier to the accumulator.
    typedef struct packed {
        logic   valid;
        word_t  p00;
        word_t  p11;
        word_t  p10;
        word_t  p01;
        word_t  bias0;
        word_t  bias1;
        logic   last;
    } prod_t;

    // Low WORD bits of the product of two fields.
    function automatic word_t mul_w(input field_t a, input field_t b);
        word_t ax;
        word_t bx;
        ax = word_t'(a);
        bx = word_t'(b);
        return ax * bx;
    endfunction

endpackage

### hdl/masked_share_dot_product_top.sv
// Top level of the masked share dot product block: one masked output row per row of items.
// Depends on msdp_pkg, msdp_cfg_regs, msdp_mult and msdp_accum.
//
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid / in_ready   in_data  (msdp_pkg::in_item_t)
//   out       output     out_valid / out_ready out_data (msdp_pkg::out_item_t)
//   cfg       input      APB, pready always 1  refresh_random at address 0
//
// One item is taken every cycle unless the pipeline holds; it passes an input
// register, the product register and the summed product register, and the
// accumulator and output register are loaded together from the last, so a row's
// result is valid once its last item has passed all three. The four 32 by 32 bit
// multipliers set the cycle time. The whole pipeline holds while a result waits
// in the output register and out_ready is low. Reset clears all valid bits, both
// accumulators and the open row flag.
module masked_share_dot_product_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  msdp_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output msdp_pkg::out_item_t           out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msdp_pkg::PADDR_W-1:0]  paddr,
    input  logic [msdp_pkg::FIELD_W-1:0]  pwdata,
    output logic [msdp_pkg::FIELD_W-1:0]  prdata,
    output logic                          pready
);
    import msdp_pkg::*;

    logic   advance;
    field_t refresh_random;
    prod_t  prod;

    // The pipeline moves unless a result is waiting to be taken.
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    msdp_cfg_regs u_cfg_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .refresh_random (refresh_random)
    );

    msdp_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_take (in_valid),
        .in_item (in_data),
        .prod    (prod)
    );

    msdp_accum u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .prod           (prod),
        .refresh_random (refresh_random),
        .out_valid      (out_valid),
        .out_item       (out_data)
    );

endmodule

### hdl/msdp_cfg_regs.sv
// APB register file of the masked share dot product block: holds refresh_random.
// Depends on msdp_pkg.
module msdp_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msdp_pkg::PADDR_W-1:0]  paddr,
    input  logic [msdp_pkg::FIELD_W-1:0]  pwdata,
    output logic [msdp_pkg::FIELD_W-1:0]  prdata,
    output logic                          pready,
    output logic [msdp_pkg::FIELD_W-1:0]  refresh_random
);
    import msdp_pkg::*;

    field_t   refresh_reg;
    field_t   refresh_next;
    reg_idx_t idx;
    logic     wr_en;

    // Decode the register index and the write strobe.
    assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        refresh_next = refresh_reg;
        if (wr_en && (idx == REG_REFRESH_RANDOM))
        begin
            refresh_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_reg <= '0;
        end
        else
        begin
            refresh_reg <= refresh_next;
        end
    end

    // Read back; addresses beyond the register list read as zero.
    always_comb
    begin
        case (idx)
            REG_REFRESH_RANDOM: prdata = refresh_reg;
            default:            prdata = '0;
        endcase
    end

    assign refresh_random = refresh_reg;

endmodule

### hdl/msdp_mult.sv
// Input register and cross product stage of the masked share dot product block.
// Depends on msdp_pkg.
module msdp_mult (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_take,
    input  msdp_pkg::in_item_t in_item,
    output msdp_pkg::prod_t    prod
);
    import msdp_pkg::*;

    logic     in_valid_reg;
    in_item_t in_item_reg;
    prod_t    prod_reg;
    prod_t    prod_next;

    // Valid bits move with the pipeline; bubbles advance as well.
    // The product register is cleared as a whole on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            prod_reg     <= '0;
        end
        else if (advance)
        begin
            in_valid_reg <= in_take;
            prod_reg     <= prod_next;
        end
    end

    // The four share cross products, one multiplier each.
    always_comb
    begin
        prod_next.valid = in_valid_reg;
        prod_next.p00   = mul_w(in_item_reg.act_share0, in_item_reg.wgt_share0);
        prod_next.p11   = mul_w(in_item_reg.act_share1, in_item_reg.wgt_share1);
        prod_next.p10   = mul_w(in_item_reg.act_share1, in_item_reg.wgt_share0);
        prod_next.p01   = mul_w(in_item_reg.act_share0, in_item_reg.wgt_share1);
        prod_next.bias0 = word_t'(in_item_reg.bias_share0);
        prod_next.bias1 = word_t'(in_item_reg.bias_share1);
        prod_next.last  = in_item_reg.row_last;
    end

    // The input item register needs no reset.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_item_reg <= in_item;
        end
    end

    assign prod = prod_reg;

endmodule

### hdl/msdp_accum.sv
// Product summing, share accumulators and output register of the masked share
// dot product block. Depends on msdp_pkg.
module msdp_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  msdp_pkg::prod_t               prod,
    input  logic [msdp_pkg::FIELD_W-1:0]  refresh_random,
    output logic                          out_valid,
    output msdp_pkg::out_item_t           out_item
);
    import msdp_pkg::*;

    // Summed products stage.
    logic      sum_valid_reg;
    word_t     psum0_reg;
    word_t     psum1_reg;
    word_t     bias0_reg;
    word_t     bias1_reg;
    logic      last_reg;

    // Share accumulators and row state.
    word_t     acc_zero_reg;
    word_t     acc_one_reg;
    logic      row_open_reg;
    word_t     acc_zero_next;
    word_t     acc_one_next;
    logic      row_open_next;
    word_t     seed0;
    word_t     seed1;

    // Output register.
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    // A row that has not opened yet starts from the refresh random and its negation.
    always_comb
    begin
        if (row_open_reg)
        begin
            seed0 = acc_zero_reg;
            seed1 = acc_one_reg;
        end
        else
        begin
            seed0 = word_t'(refresh_random);
            seed1 = word_t'(0) - word_t'(refresh_random);
        end
    end

    // Accumulate, and close the row on its last item.
    always_comb
    begin
        acc_zero_next  = acc_zero_reg;
        acc_one_next   = acc_one_reg;
        row_open_next  = row_open_reg;
        out_valid_next = 1'b0;
        out_item_next.sum_share0 = field_t'(seed0 + psum0_reg + bias0_reg);
        out_item_next.sum_share1 = field_t'(seed1 + psum1_reg + bias1_reg);
        if (sum_valid_reg)
        begin
            acc_zero_next  = seed0 + psum0_reg;
            acc_one_next   = seed1 + psum1_reg;
            row_open_next  = !last_reg;
            out_valid_next = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            acc_zero_reg  <= '0;
            acc_one_reg   <= '0;
            row_open_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sum_valid_reg <= prod.valid;
            acc_zero_reg  <= acc_zero_next;
            acc_one_reg   <= acc_one_next;
            row_open_reg  <= row_open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            psum0_reg    <= prod.p11 + prod.p00;
            psum1_reg    <= prod.p10 + prod.p01;
            bias0_reg    <= prod.bias0;
            bias1_reg    <= prod.bias1;
            last_reg     <= prod.last;
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
